// ===== hdl/spectrum_averager_autolevel_unit_macros.svh =====
// assertion macros for the spectrum averager
`ifndef SPECTRUM_AVERAGER_AUTOLEVEL_UNIT_MACROS_SVH
`define SPECTRUM_AVERAGER_AUTOLEVEL_UNIT_MACROS_SVH

// same-cycle implication
`define SPAA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPAA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/spaa_pkg.sv =====
// shared types, constants and helpers of the spectrum averager
`default_nettype none
package spaa_pkg;
    localparam int DEF_MAX_PIXELS = 2048;
    localparam int SMP_W   = 13;
    localparam int AVG_W   = 16;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 13;
    localparam int IN_TW   = 16;
    localparam int OUT_TW  = 64;
    localparam int IDX_W   = 11;

    typedef enum logic [CFG_IW-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_AVG_GAIN     = 3'd1,
        REG_SETTLE       = 3'd2,
        REG_FLOOR_RANK   = 3'd3,
        REG_TARGET_FLOOR = 3'd4,
        REG_MANUAL_EN    = 3'd5,
        REG_MANUAL_OFS   = 3'd6,
        REG_UNUSED       = 3'd7
    } t_reg_idx;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_UPD    = 9'b000000010,
        S_OUT    = 9'b000000100,
        S_SINIT  = 9'b000001000,
        S_SCAN   = 9'b000010000,
        S_DECIDE = 9'b000100000,
        S_LOCK   = 9'b001000000,
        S_SHIFT  = 9'b010000000,
        S_REPORT = 9'b100000000
    } t_state;

    typedef struct packed {
        logic accept;
        logic update;
        logic advance;
        logic sel_init;
        logic scan;
        logic decide;
        logic lock;
        logic shift;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic locked;
        logic lock_due;
        logic out_free;
        logic sweep_done;
        logic bit_zero;
    } t_stat;

    function automatic logic signed [AVG_W-1:0] sat16(input logic signed [20:0] v);
        if (v > 21'sd32767)       return 16'sh7FFF;
        else if (v < -21'sd32768) return 16'sh8000;
        else                      return v[AVG_W-1:0];
    endfunction

    function automatic logic signed [SMP_W-1:0] sat13(input logic signed [20:0] v);
        if (v > 21'sd4095)       return 13'sh0FFF;
        else if (v < -21'sd4096) return 13'sh1000;
        else                     return v[SMP_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== hdl/spaa_ctrl.sv =====
// sequencing state machine of the spectrum averager
`default_nettype none
module spaa_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_beat,
    input  wire spaa_pkg::t_stat i_stat,
    output spaa_pkg::t_cmd   o_cmd,
    output logic             o_in_ready
);
    import spaa_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_beat) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.locked || i_stat.out_free) begin
                    o_cmd.advance = 1'b1;
                    n_state = i_stat.lock_due ? S_SINIT : S_IDLE;
                end
            end
            S_SINIT: begin
                o_cmd.sel_init = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.sweep_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_stat.bit_zero ? S_LOCK : S_SCAN;
            end
            S_LOCK: begin
                o_cmd.lock = 1'b1;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.sweep_done) n_state = S_REPORT;
            end
            S_REPORT: begin
                if (i_stat.out_free) begin
                    o_cmd.report = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== hdl/spaa_dp.sv =====
// average store, update arithmetic, rank selection and output register
`default_nettype none
module spaa_dp #(
    parameter int MAX_PIXELS = spaa_pkg::DEF_MAX_PIXELS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire spaa_pkg::t_cmd          i_cmd,
    output spaa_pkg::t_stat              o_stat,
    input  wire                          i_cfg_we,
    input  wire [spaa_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire [spaa_pkg::CFG_DW-1:0]   i_cfg_data,
    input  wire [spaa_pkg::SMP_W-1:0]    i_sample,
    input  wire                          i_out_taken,
    output logic                         o_out_valid,
    output logic [spaa_pkg::OUT_TW-1:0]  o_out_data,
    output logic                         o_out_kind,
    output logic                         o_out_last
);
    import spaa_pkg::*;

    localparam int PW = $clog2(MAX_PIXELS);
    localparam int NW = $clog2(MAX_PIXELS + 1);

    logic [11:0] r_fw;
    logic [8:0]  r_gain;
    logic [5:0]  r_settle;
    logic [10:0] r_rank;
    logic signed [SMP_W-1:0] r_target, r_mofs;
    logic r_men;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw     <= 12'd2048;
            r_gain   <= 9'd141;
            r_settle <= 6'd15;
            r_rank   <= 11'd409;
            r_target <= -13'sd1840;
            r_men    <= 1'b0;
            r_mofs   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_FRAME_WIDTH:  r_fw     <= i_cfg_data[11:0];
                REG_AVG_GAIN:     r_gain   <= i_cfg_data[8:0];
                REG_SETTLE:       r_settle <= i_cfg_data[5:0];
                REG_FLOOR_RANK:   r_rank   <= i_cfg_data[10:0];
                REG_TARGET_FLOOR: r_target <= i_cfg_data;
                REG_MANUAL_EN:    r_men    <= i_cfg_data[0];
                REG_MANUAL_OFS:   r_mofs   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame width and rank
    logic [NW-1:0] w_n, w_k0;
    always_comb begin
        if (r_fw == '0)                     w_n = NW'(1);
        else if (32'(r_fw) > MAX_PIXELS)    w_n = NW'(MAX_PIXELS);
        else                                w_n = NW'(r_fw);
        if (32'(r_rank) >= 32'(w_n))        w_k0 = w_n - NW'(1);
        else                                w_k0 = NW'(r_rank);
    end

    // state
    logic [PW-1:0] r_pos;
    logic [5:0]    r_cnt;
    logic          r_primed, r_locked;
    logic signed [SMP_W-1:0] r_doff, r_fl13;
    logic signed [AVG_W-1:0] r_peak, r_new;
    logic signed [SMP_W-1:0] r_smp;

    // memory
    logic signed [AVG_W-1:0] r_mem [MAX_PIXELS];
    logic signed [AVG_W-1:0] r_rdata;
    logic [PW-1:0] w_raddr, w_waddr;
    logic signed [AVG_W-1:0] w_wdata;
    logic w_we;

    logic [NW-1:0] r_scan, r_cntm, r_k;
    logic [PW-1:0] r_sa, r_rpos;
    logic          r_sv;
    logic [3:0]    r_bit;
    logic [AVG_W-1:0] r_prefix;

    assign w_raddr = (i_cmd.scan || i_cmd.shift) ? r_scan[PW-1:0] : r_pos;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_raddr];
        if (w_we) r_mem[w_waddr] <= w_wdata;
    end

    // per-pixel update
    logic [8:0] w_g;
    logic signed [17:0] w_diff;
    logic signed [27:0] w_prod;
    logic signed [20:0] w_sum;
    logic signed [AVG_W-1:0] w_upd;
    logic signed [SMP_W-1:0] w_off;
    always_comb begin
        w_g    = (r_gain > 9'd256) ? 9'd256 : r_gain;
        w_off  = r_locked ? r_doff : '0;
        w_diff = 18'(r_smp) + 18'(w_off) - 18'(r_rdata);
        w_prod = $signed({1'b0, w_g}) * w_diff;
        w_sum  = 21'(r_rdata) + 21'(w_prod >>> 8);
        w_upd  = r_primed ? sat16(w_sum) : AVG_W'(r_smp);
    end

    // frame bookkeeping
    logic       w_last, w_due;
    logic [5:0] w_cinc, w_need;
    always_comb begin
        w_last = (NW'(r_pos) + NW'(1)) >= w_n;
        w_cinc = !r_primed ? 6'd1 : (r_cnt < 6'd63 ? r_cnt + 6'd1 : r_cnt);
        w_need = (r_settle == '0) ? 6'd1 : r_settle;
        w_due  = !r_locked && w_last && (w_cinc >= w_need);
    end

    // pixel outputs
    logic signed [AVG_W-1:0] w_pk;
    logic signed [20:0] w_b;
    logic [7:0] w_byte;
    always_comb begin
        w_pk = (r_pos == '0 || r_new > r_peak) ? r_new : r_peak;
        w_b  = 21'(r_new) + 21'sd3200;
        if (w_b < 0)                 w_byte = 8'd0;
        else if (w_b[20:4] > 17'd255) w_byte = 8'd255;
        else                         w_byte = w_b[11:4];
    end

    // rank selection on offset-binary keys
    logic [AVG_W-1:0] w_key, w_hmask;
    logic w_match;
    always_comb begin
        w_key   = r_rdata ^ 16'h8000;
        w_hmask = (16'hFFFF << r_bit) << 1;
        w_match = ((w_key & w_hmask) == (r_prefix & w_hmask)) && !w_key[r_bit];
    end

    logic signed [AVG_W-1:0] w_fl;
    logic signed [SMP_W-1:0] w_ofs;
    always_comb begin
        w_fl  = $signed(r_prefix ^ 16'h8000);
        w_ofs = r_men ? r_mofs : sat13(21'(r_target) - 21'(w_fl));
    end

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_pos;
        w_wdata = w_upd;
        if (i_cmd.update) w_we = 1'b1;
        else if (i_cmd.shift && r_sv) begin
            w_we = 1'b1;
            w_waddr = r_sa;
            w_wdata = sat16(21'(r_rdata) + 21'(r_doff));
        end
    end

    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_cnt <= '0; r_primed <= 1'b0; r_locked <= 1'b0;
            r_doff <= '0; r_peak <= '0; r_ov <= 1'b0; r_sv <= 1'b0; r_scan <= '0;
        end else begin
            if ((i_cmd.advance && r_locked) || i_cmd.report) r_ov <= 1'b1;
            else if (i_out_taken)                            r_ov <= 1'b0;
            if (i_cmd.accept) r_smp <= i_sample;
            if (i_cmd.update) r_new <= w_upd;
            if (i_cmd.advance) begin
                if (r_locked) begin
                    r_peak <= w_pk;
                    o_out_kind <= 1'b0;
                    o_out_last <= w_last;
                    o_out_data <= {6'd0, 13'd0, r_doff, sat13(21'(w_pk)), w_byte,
                                   IDX_W'(r_pos)};
                end
                if (w_last) begin
                    r_pos <= '0;
                    r_primed <= 1'b1;
                    if (!r_locked) r_cnt <= w_cinc;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
                r_rpos <= r_pos;
            end
            if (i_cmd.sel_init) begin
                r_prefix <= '0; r_k <= w_k0; r_bit <= 4'd15;
                r_scan <= '0; r_sv <= 1'b0; r_cntm <= '0;
            end
            if (i_cmd.scan) begin
                r_sv <= r_scan < w_n;
                if (r_scan < w_n) r_scan <= r_scan + NW'(1);
                if (r_sv && w_match) r_cntm <= r_cntm + NW'(1);
            end
            if (i_cmd.decide) begin
                if (r_k >= r_cntm) begin
                    r_prefix[r_bit] <= 1'b1;
                    r_k <= r_k - r_cntm;
                end
                r_bit <= r_bit - 4'd1;
                r_cntm <= '0; r_scan <= '0; r_sv <= 1'b0;
            end
            if (i_cmd.lock) begin
                r_doff <= w_ofs;
                r_fl13 <= sat13(21'(w_fl));
                r_scan <= '0; r_sv <= 1'b0;
            end
            if (i_cmd.shift) begin
                r_sv <= r_scan < w_n;
                r_sa <= r_scan[PW-1:0];
                if (r_scan < w_n) r_scan <= r_scan + NW'(1);
            end
            if (i_cmd.report) begin
                r_locked <= 1'b1;
                o_out_kind <= 1'b1;
                o_out_last <= 1'b1;
                o_out_data <= {6'd0, r_fl13, r_doff, 13'd0, 8'd0, IDX_W'(r_rpos)};
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_stat.locked     = r_locked;
    assign o_stat.lock_due   = w_due;
    assign o_stat.out_free   = !r_ov || i_out_taken;
    assign o_stat.sweep_done = (r_scan == w_n) && !r_sv;
    assign o_stat.bit_zero   = (r_bit == 4'd0);
endmodule
`default_nettype wire

// ===== hdl/spectrum_averager_autolevel_unit.sv =====
// Spectrum averager with automatic display level, top level.
// Input stream: one pixel per beat, s_axis_tdata[12:0] signed level in 1/16 dB.
// Config port: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data; write
// only while idle. o_cfg_ready is always high.
// Output stream: m_axis_tuser 0 for a pixel beat, 1 for the lock report;
// m_axis_tlast marks the last pixel of a frame.
// Each pixel passes through accept, read-modify-write of the average store
// and output load; the next pixel is taken only after that output load.
// The store has one read and one write port; a pixel is not taken before the last is through.
// The lock frame adds 16 selection sweeps (scan and decision) and one offset
// sweep before the lock report is loaded.
// No pixel beats appear before lock; the lock report replaces that frame's row.
// Reset restores the register defaults, clears frame state and the lock.
// The average store needs no clearing: the first frame fills it.
// A stalled receiver holds the output register; the block then waits at the
// next output load and stops taking pixels.
`default_nettype none
module spectrum_averager_autolevel_unit #(
    parameter int MAX_PIXELS = spaa_pkg::DEF_MAX_PIXELS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [spaa_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire [spaa_pkg::CFG_DW-1:0]   i_cfg_data,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // [12:0] sample_level, [15:13] zero
    input  wire [spaa_pkg::IN_TW-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // [10:0] pixel_index, [18:11] level_byte, [31:19] running_peak,
    // [44:32] applied_offset, [57:45] measured_floor, [63:58] zero
    output logic [spaa_pkg::OUT_TW-1:0]  m_axis_tdata,
    // [0] result_kind
    output logic                         m_axis_tuser,
    output logic                         m_axis_tlast
);
    import spaa_pkg::*;
    `include "spectrum_averager_autolevel_unit_macros.svh"

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_beat, w_out_taken;

    assign o_cfg_ready = 1'b1;
    assign w_in_beat   = s_axis_tvalid && s_axis_tready;
    assign w_out_taken = m_axis_tvalid && m_axis_tready;

    spaa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_beat  (w_in_beat),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    spaa_dp #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (s_axis_tdata[SMP_W-1:0]),
        .i_out_taken (w_out_taken),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    `SPAA_ASSERT_NOW(a_pix_only_locked, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, w_stat.locked, "pixel beat before lock")
    `SPAA_ASSERT_NEXT(a_lock_sticks, i_clk, i_rst_n, w_stat.locked, w_stat.locked, "lock lost")
    `SPAA_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, w_in_beat, !s_axis_tready, "second pixel taken too early")
endmodule
`default_nettype wire

// ===== tb/spectrum_averager_autolevel_unit_tb.sv =====
// testbench of the spectrum averager: directed table and random pixel streams, self-checking
`timescale 1ns / 100ps
`default_nettype none
module spectrum_averager_autolevel_unit_tb;
    import spaa_pkg::*;

    typedef struct {
        logic              kind;
        logic [10:0]       pix;
        logic [7:0]        lvl;
        logic [12:0]       peak;
        logic              row_end;
        logic [12:0]       ofs;
        logic [12:0]       flr;
    } t_spec_beat;

    typedef enum logic [1:0] {PIN_NONE, PIN_PIXEL, PIN_LOCK} t_spec_pin;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [IN_TW-1:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [OUT_TW-1:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    spectrum_averager_autolevel_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // averager model state
    int unsigned cfg_width, cfg_gain, cfg_settle, cfg_rank, cfg_man_en;
    int          cfg_target, cfg_man_ofs;
    int          avg_mem [DEF_MAX_PIXELS];
    int          sel_buf [DEF_MAX_PIXELS];
    int unsigned pix_pos, frames_seen;
    bit          primed, locked;
    int          disp_ofs, peak_lvl;

    t_spec_beat  expected_beats [$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          beats_seen = 0;
    int          reg_writes = 0;
    bit          rx_idle_on = 1'b0;
    bit          tx_idle_on = 1'b0;

    logic signed [12:0] dir_samples [24] = '{
        -13'sd4096, 13'sd4095, 13'sd0, -13'sd1, 13'sd1, -13'sd2048, 13'sd2047, 13'sd100,
        -13'sd300, 13'sd4095, -13'sd4096, 13'sd5, -13'sd5, 13'sd1000, -13'sd1000, 13'sd0,
        13'sd4095, -13'sd4096, 13'sd0, -13'sd1, 13'sd2730, -13'sd2731, 13'sd64, -13'sd64
    };
    t_spec_pin dir_pin [24] = '{
        PIN_NONE, PIN_NONE, PIN_NONE, PIN_NONE, PIN_NONE, PIN_NONE, PIN_NONE, PIN_NONE,
        PIN_NONE, PIN_NONE, PIN_NONE, PIN_NONE, PIN_NONE, PIN_NONE, PIN_NONE, PIN_LOCK,
        PIN_PIXEL, PIN_PIXEL, PIN_PIXEL, PIN_PIXEL, PIN_PIXEL, PIN_PIXEL, PIN_PIXEL, PIN_PIXEL
    };

    function automatic int clamp(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void apply_reg(input t_reg_idx idx, input logic [CFG_DW-1:0] d);
        case (idx)
            REG_FRAME_WIDTH:  cfg_width = d[11:0];
            REG_AVG_GAIN:     cfg_gain = d[8:0];
            REG_SETTLE:       cfg_settle = d[5:0];
            REG_FLOOR_RANK:   cfg_rank = d[10:0];
            REG_TARGET_FLOOR: cfg_target = $signed(d[12:0]);
            REG_MANUAL_EN:    cfg_man_en = d[0];
            REG_MANUAL_OFS:   cfg_man_ofs = $signed(d[12:0]);
            default: ;
        endcase
    endfunction

    function automatic int pick_floor(input int unsigned n);
        int unsigned i, j, r;
        int v;
        for (i = 0; i < n; i++) sel_buf[i] = avg_mem[i];
        for (i = 1; i < n; i++) begin
            v = sel_buf[i];
            j = i;
            while (j > 0 && sel_buf[j-1] > v) begin
                sel_buf[j] = sel_buf[j-1];
                j--;
            end
            sel_buf[j] = v;
        end
        r = cfg_rank >= n ? n - 1 : cfg_rank;
        return sel_buf[r];
    endfunction

    function automatic bit average_pixel(input logic signed [12:0] s, output t_spec_beat r);
        int unsigned n, p, i;
        bit last, got;
        int g, diff, a, b, fl, off;
        n = cfg_width == 0 ? 1 : (cfg_width > DEF_MAX_PIXELS ? DEF_MAX_PIXELS : cfg_width);
        p = pix_pos;
        last = (p + 1 >= n);
        g = cfg_gain > 256 ? 256 : cfg_gain;
        got = 1'b0;
        r = '{default: '0};
        if (!primed) begin
            avg_mem[p] = s;
        end else begin
            diff = int'(s) + (locked ? disp_ofs : 0) - avg_mem[p];
            avg_mem[p] = clamp(avg_mem[p] + ((g * diff) >>> 8), -32768, 32767);
        end
        if (locked) begin
            a = avg_mem[p];
            b = a + 3200;
            if (p == 0 || a > peak_lvl) peak_lvl = a;
            r.kind = 1'b0;
            r.pix = p[10:0];
            r.lvl = b < 0 ? 8'd0 : (b / 16 > 255 ? 8'd255 : 8'(b / 16));
            r.peak = 13'(clamp(peak_lvl, -4096, 4095));
            r.row_end = last;
            r.ofs = 13'(disp_ofs);
            got = 1'b1;
        end
        if (!last) begin
            pix_pos = p + 1;
            return got;
        end
        pix_pos = 0;
        if (!primed) begin
            primed = 1'b1;
            frames_seen = 0;
        end
        if (!locked) begin
            if (frames_seen < 63) frames_seen++;
            if (frames_seen < (cfg_settle == 0 ? 1 : cfg_settle)) return got;
            fl = pick_floor(n);
            off = cfg_man_en ? cfg_man_ofs : clamp(cfg_target - fl, -4096, 4095);
            disp_ofs = off;
            for (i = 0; i < n; i++) avg_mem[i] = clamp(avg_mem[i] + off, -32768, 32767);
            locked = 1'b1;
            r = '{default: '0};
            r.kind = 1'b1;
            r.pix = p[10:0];
            r.row_end = 1'b1;
            r.ofs = 13'(off);
            r.flr = 13'(clamp(fl, -4096, 4095));
            got = 1'b1;
        end
        return got;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DW-1:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, d);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic signed [12:0] s, output bit got, output t_spec_beat r);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, s};
        do @(posedge i_clk); while (!s_axis_tready);
        got = average_pixel(s, r);
        if (got) expected_beats.push_back(r);
        pixels_sent++;
    endtask

    task automatic settle_idle;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    // result sink with random stalls and one long hold-off
    initial begin : sink
        int gap;
        t_spec_beat e;
        forever begin
            gap = rx_idle_on ? $urandom_range(0, 9) : 0;
            if (beats_seen == 120) gap = 300;
            @(negedge i_clk);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
            beats_seen++;
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none actual %h user %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                e = expected_beats.pop_front();
                check_field("result_kind", e.kind, m_axis_tuser);
                check_field("pixel_index", e.pix, m_axis_tdata[10:0]);
                check_field("level_byte", e.lvl, m_axis_tdata[18:11]);
                check_field("running_peak", e.peak, m_axis_tdata[31:19]);
                check_field("row_end", e.row_end, m_axis_tlast);
                check_field("applied_offset", e.ofs, m_axis_tdata[44:32]);
                check_field("measured_floor", e.flr, m_axis_tdata[57:45]);
                check_field("pad", 0, m_axis_tdata[63:58]);
            end
        end
    end

    initial begin : watchdog
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        bit got;
        t_spec_beat r;
        int phase, k, len;
        cfg_width = 2048; cfg_gain = 141; cfg_settle = 15; cfg_rank = 409;
        cfg_target = -1840; cfg_man_en = 0; cfg_man_ofs = 0;
        pix_pos = 0; frames_seen = 0; primed = 0; locked = 0; disp_ofs = 0; peak_lvl = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes first, then the setting used for the lock
        write_reg(REG_FRAME_WIDTH, 13'd4095);
        write_reg(REG_FRAME_WIDTH, 13'd8);
        write_reg(REG_AVG_GAIN, 13'd511);
        write_reg(REG_AVG_GAIN, 13'd256);
        write_reg(REG_SETTLE, 13'd63);
        write_reg(REG_SETTLE, 13'd2);
        write_reg(REG_FLOOR_RANK, 13'd2047);
        write_reg(REG_FLOOR_RANK, 13'($urandom_range(0, 9)));
        write_reg(REG_TARGET_FLOOR, 13'h1000);
        write_reg(REG_TARGET_FLOOR, 13'($urandom_range(0, 8191)));
        write_reg(REG_MANUAL_EN, 13'd1);
        write_reg(REG_MANUAL_EN, 13'($urandom_range(0, 1)));
        write_reg(REG_MANUAL_OFS, 13'h0FFF);
        write_reg(REG_MANUAL_OFS, 13'($urandom_range(0, 8191)));

        for (k = 0; k < 24; k++) begin
            send_pixel(dir_samples[k], got, r);
            if ((dir_pin[k] == PIN_NONE && got) || (dir_pin[k] != PIN_NONE && !got) ||
                (got && r.kind != (dir_pin[k] == PIN_LOCK))) begin
                errors++;
                $display("%0t: row %0d expected pin %s actual result %b kind %b",
                         $time, k, dir_pin[k].name(), got, r.kind);
            end
        end
        settle_idle();

        for (phase = 0; phase < 10; phase++) begin
            tx_idle_on = (phase % 3) != 0;
            rx_idle_on = (phase % 3) != 2;
            case (phase % 5)
                0: write_reg(REG_AVG_GAIN, 13'd0);
                1: write_reg(REG_AVG_GAIN, 13'd1);
                2: write_reg(REG_AVG_GAIN, 13'd256);
                3: write_reg(REG_AVG_GAIN, 13'd511);
                default: write_reg(REG_AVG_GAIN, 13'($urandom_range(2, 255)));
            endcase
            write_reg(REG_FRAME_WIDTH, 13'(phase == 4 ? 0 : (phase == 7 ? 1 :
                                          $urandom_range(2, 8))));
            write_reg(REG_SETTLE, 13'($urandom_range(0, 63)));
            write_reg(REG_FLOOR_RANK, 13'($urandom_range(0, 2047)));
            write_reg(REG_TARGET_FLOOR, 13'($urandom_range(0, 8191)));
            write_reg(REG_MANUAL_EN, 13'($urandom_range(0, 1)));
            write_reg(REG_MANUAL_OFS, 13'($urandom_range(0, 8191)));
            len = $urandom_range(35, 50);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_pixel(($urandom_range(0, 1) ? 13'sh0FFF : 13'sh1000), got, r);
                else
                    send_pixel(13'($urandom_range(0, 8191)), got, r);
            end
            settle_idle();
        end

        $display("run covered %0d pixel beats in, %0d result beats out, %0d register writes",
                 pixels_sent, beats_seen, reg_writes);
        $display("lock offset %0d, gain settings 0 to 511, frame widths 0 to 8", disp_ofs);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
